[hdl/uvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvt_pkg
// Shared types and codes for the unordered value table and its cells.
// ----------------------------------------------------------------------------
package uvt_pkg;

	localparam int VALUE_W = 32;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int CNT_W   = 5;
	localparam int OUT_W   = 16;

	// request operation codes
	typedef enum logic [MODE_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_SEARCH = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic start;  // load the search token into the head cell
		logic scan;   // token may move one cell forward
		logic shift;  // delete commit: cells at and after the hit take their neighbor
	} cell_ctl_t;

endpackage

[hdl/uvt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvt_cell
// One table slot: holds a value, compares it with the search key, relays the
// search token to the next slot and takes its neighbor's value on delete.
// ----------------------------------------------------------------------------
module uvt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  uvt_pkg::cell_ctl_t           ctl,
	input  logic [uvt_pkg::VALUE_W-1:0]  key,
	input  logic [uvt_pkg::VALUE_W-1:0]  wr_data,
	input  logic                         wr_sel,
	input  logic                         occ,
	input  logic                         shift_ok,
	input  logic                         head,
	input  logic                         tok_in,
	input  logic [uvt_pkg::VALUE_W-1:0]  next_entry,
	output logic [uvt_pkg::VALUE_W-1:0]  entry,
	output logic                         tok_out,
	output logic                         tok,
	output logic                         hit,
	output logic                         miss
);
	import uvt_pkg::*;

	logic [VALUE_W-1:0] entry_q;
	logic               tok_q;
	logic               passed_q;
	logic               match;

	// compare against the broadcast key
	assign match   = (entry_q == key);
	assign hit     = tok_q & occ & match;
	assign miss    = tok_q & ~occ;
	assign tok_out = tok_q & ctl.scan & occ & ~match;
	assign tok     = tok_q;
	assign entry   = entry_q;

	// token and passed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			passed_q <= 1'b0;
		end else if (ctl.start) begin
			tok_q    <= head;
			passed_q <= 1'b0;
		end else if (ctl.scan) begin
			tok_q <= tok_in;
			if (tok_out) begin
				passed_q <= 1'b1;
			end
		end
	end

	// stored value: append write or close-up shift on delete
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			entry_q <= wr_data;
		end else if (ctl.shift && !passed_q && shift_ok) begin
			entry_q <= next_entry;
		end
	end

endmodule

[hdl/unordered_value_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_value_table
// Bounded insertion-ordered table of 32-bit values with linear search.
// ----------------------------------------------------------------------------
// One request is handled at a time. Clear and insert finish in the accept
// cycle; their result is then loaded into the output register from the
// response state once that register is free. Search and delete pass a token
// down the row of cells, one cell per clock, so the token position sets the
// time: a search ends at the matching cell, or with a miss at the first empty
// cell or where the token runs off the last cell of a full table. A delete
// closes the gap in the same cycle the match is seen. The output register keeps
// a result available while the next request is accepted and worked on.
// ----------------------------------------------------------------------------
module unordered_value_table #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [5:2] position, [10:6] entry_count
);
	import uvt_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t             state_q;
	op_t                op_q;
	op_t                op_in;
	logic [VALUE_W-1:0] key_q;
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      pos_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [PW-1:0]      res_pos_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic               s_accept;
	logic               full;
	logic               hit_any;
	logic               miss_any;
	logic               load_out;
	cell_ctl_t          ctl;

	logic [DEPTH-1:0]   occ;
	logic [DEPTH-1:0]   shift_ok;
	logic [DEPTH-1:0]   wr_sel;
	logic [DEPTH-1:0]   tok;
	logic [DEPTH-1:0]   tok_out;
	logic [DEPTH-1:0]   hit;
	logic [DEPTH-1:0]   miss;
	logic [DEPTH-1:0]   tok_in;
	logic [VALUE_W-1:0] entry [DEPTH];
	logic [VALUE_W-1:0] next_entry [DEPTH];

	logic [PW+POS_W-1:0] pos_wide;
	logic [CW+CNT_W-1:0] cnt_wide;

	assign op_in    = op_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid & s_tready;
	assign full     = (count_q == CW'(DEPTH));
	assign hit_any  = |hit;
	assign miss_any = (|miss) | tok_out[DEPTH-1];
	assign load_out = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);

	// control broadcast to the cells
	always_comb begin
		ctl.start = s_accept && (op_in == OP_SEARCH || op_in == OP_DELETE);
		ctl.scan  = (state_q == ST_SCAN);
		ctl.shift = (state_q == ST_SCAN) && (op_q == OP_DELETE) && hit_any;
	end

	// per-cell occupancy, write select and token chain wiring
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i]      = (CW'(i) < count_q);
			shift_ok[i] = (CW'(i + 1) < count_q);
			wr_sel[i]   = s_accept && (op_in == OP_INSERT) && (CW'(i) == count_q);
			tok_in[i]   = (i == 0) ? 1'b0 : tok_out[(i == 0) ? 0 : i - 1];
			next_entry[i] = (i == DEPTH - 1) ? '0 : entry[(i == DEPTH - 1) ? i : i + 1];
		end
	end

	// row of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		uvt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key_q),
			.wr_data    (s_tdata),
			.wr_sel     (wr_sel[g]),
			.occ        (occ[g]),
			.shift_ok   (shift_ok[g]),
			.head       (g == 0),
			.tok_in     (tok_in[g]),
			.next_entry (next_entry[g]),
			.entry      (entry[g]),
			.tok_out    (tok_out[g]),
			.tok        (tok[g]),
			.hit        (hit[g]),
			.miss       (miss[g])
		);
	end

	// sequencer, count and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_CLEAR;
			count_q      <= '0;
			pos_q        <= '0;
			res_status_q <= ST_OK;
			res_pos_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						op_q      <= op_in;
						pos_q     <= '0;
						res_pos_q <= '0;
						case (op_in)
							OP_CLEAR: begin
								count_q      <= '0;
								res_status_q <= ST_OK;
								state_q      <= ST_RESP;
							end
							OP_INSERT: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									count_q      <= count_q + CW'(1);
									res_status_q <= ST_OK;
								end
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit_any) begin
						res_status_q <= ST_OK;
						res_pos_q    <= pos_q;
						if (op_q == OP_DELETE) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= ST_RESP;
					end else if (miss_any) begin
						res_status_q <= ST_NOT_FOUND;
						res_pos_q    <= '0;
						state_q      <= ST_RESP;
					end else begin
						pos_q <= pos_q + PW'(1);
					end
				end
				ST_RESP: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search key capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			key_q <= s_tdata;
		end
	end

	// output register
	assign pos_wide = {{POS_W{1'b0}}, res_pos_q};
	assign cnt_wide = {{CNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {{(OUT_W - STAT_W - POS_W - CNT_W){1'b0}},
				cnt_wide[CNT_W-1:0], pos_wide[POS_W-1:0], res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> $onehot0(tok))
		else $error("more than one search token in the row");

	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !(hit_any && miss_any))
		else $error("search reports hit and miss together");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not drop the entry count");

endmodule

[sim/unordered_value_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_value_table_tb
// Self-checking bench for the bounded insertion-ordered value table.
// ----------------------------------------------------------------------------
// A queue of requests filled up front feeds a clocked driver. Every accepted
// request runs through a local table model that produces the expected status,
// position and count. A clocked monitor takes results under random back
// pressure and checks them in order. Directed requests cover empty, full,
// duplicate and extreme-value cases, then a long random mix follows.
// ----------------------------------------------------------------------------
module unordered_value_table_tb;

	import uvt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_REQS = 525;

	typedef struct packed {
		logic        drain;  // hold the sender until all results are back
		op_t         mode;
		logic [31:0] value;
	} table_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  position;
		logic [CNT_W-1:0]  entry_count;
	} table_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [1:0]  s_tuser = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [1:0] status, [5:2] position, [10:6] entry_count

	// model of the table contents
	logic [31:0] model_slots [TABLE_DEPTH];
	int          model_held = 0;

	table_req_t  req_queue [$];
	table_rsp_t  rsp_queue [$];
	int          fail_count = 0;

	unordered_value_table #(
		.DEPTH(TABLE_DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #2 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// apply one request to the model and return the result it should give
	function automatic table_rsp_t table_apply(op_t mode, logic [31:0] value);
		table_rsp_t rsp;
		int hit;
		int i;
		rsp = '0;
		rsp.status = ST_OK;
		hit = -1;
		case (mode)
			OP_CLEAR: begin
				model_held = 0;
			end
			OP_INSERT: begin
				if (model_held < TABLE_DEPTH) begin
					model_slots[model_held] = value;
					model_held++;
				end else begin
					rsp.status = ST_FULL;
				end
			end
			default: begin
				for (i = 0; i < model_held; i++)
					if (hit < 0 && model_slots[i] == value)
						hit = i;
				if (hit < 0) begin
					rsp.status = ST_NOT_FOUND;
				end else begin
					rsp.position = hit[POS_W-1:0];
					// delete closes the gap, keeping order
					if (mode == OP_DELETE) begin
						for (i = hit; i < model_held - 1; i++)
							model_slots[i] = model_slots[i + 1];
						model_held--;
					end
				end
			end
		endcase
		rsp.entry_count = model_held[CNT_W-1:0];
		return rsp;
	endfunction

	// request driver
	int         tx_idle = 0;
	logic       tx_calm = 1'b0;
	table_req_t tx_cur = '0;

	always @(posedge clk or negedge arst_n) begin
		logic       fire;
		logic       next_valid;
		table_rsp_t exp_rsp;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				exp_rsp = table_apply(tx_cur.mode, tx_cur.value);
				rsp_queue = {rsp_queue, exp_rsp};
				if ($urandom_range(0, 49) == 0)
					tx_calm = ~tx_calm;
				tx_idle = tx_calm ? 0 : idle_len();
			end
			if (fire || !s_tvalid) begin
				next_valid = 1'b0;
				if (tx_idle > 0) begin
					tx_idle--;
				end else if (req_queue.size() > 0) begin
					if (req_queue[0].drain) begin
						if (rsp_queue.size() == 0)
							void'(req_queue.pop_front());
					end else begin
						tx_cur = req_queue.pop_front();
						next_valid = 1'b1;
					end
				end
				s_tvalid <= next_valid;
				s_tdata <= tx_cur.value;
				s_tuser <= tx_cur.mode;
			end
		end
	end

	// result monitor with random back pressure
	int   rx_stall = 0;
	logic rx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		table_rsp_t want;
		table_rsp_t got;
		logic       ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.position = m_tdata[5:2];
				got.entry_count = m_tdata[10:6];
				if (rsp_queue.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = rsp_queue.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.position !== want.position) begin
						$error("position: expected %0d, actual %0d",
							want.position, got.position);
						fail_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, got.entry_count);
						fail_count++;
					end
				end
			end
			if ($urandom_range(0, 199) == 0)
				rx_calm = ~rx_calm;
			if (rx_stall > 0) begin
				rx_stall--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					rx_stall = idle_len();
			end
			m_tready <= ready_next;
		end
	end

	task automatic push_req(op_t mode, logic [31:0] value);
		table_req_t item;
		item = '{drain: 1'b0, mode: mode, value: value};
		req_queue = {req_queue, item};
	endtask

	task automatic push_drain();
		table_req_t item;
		item = '{drain: 1'b1, mode: OP_CLEAR, value: '0};
		req_queue = {req_queue, item};
	endtask

	// stimulus, reset and end of run
	initial begin
		logic [31:0] pool [16];
		int          pool_n;
		int          n;
		int          i;
		int          r;
		logic [31:0] v;

		// empty table misses
		push_req(OP_SEARCH, 32'h0000_0000);
		push_req(OP_DELETE, 32'hFFFF_FFFF);
		// fill to capacity with extremes and a duplicate
		push_req(OP_INSERT, 32'h8000_0000);
		push_req(OP_INSERT, 32'h7FFF_FFFF);
		push_req(OP_INSERT, 32'h0000_0000);
		push_req(OP_INSERT, 32'hFFFF_FFFF);
		push_req(OP_INSERT, 32'hFFFF_FFFF);
		for (i = 5; i < TABLE_DEPTH - 1; i++)
			push_req(OP_INSERT, 32'h1000_0000 + i);
		push_req(OP_INSERT, 32'hA5A5_5A5A);
		push_req(OP_INSERT, 32'h1234_5678);  // rejected, table full
		push_req(OP_SEARCH, 32'hA5A5_5A5A);  // last slot
		push_req(OP_SEARCH, 32'hFFFF_FFFF);  // first of two equal entries
		push_req(OP_DELETE, 32'hFFFF_FFFF);
		push_req(OP_SEARCH, 32'h1234_5678);
		push_req(OP_DELETE, 32'hA5A5_5A5A);
		push_req(OP_DELETE, 32'h8000_0000);
		push_req(OP_CLEAR, 32'hFFFF_FFFF);
		// stale contents are no longer counted
		push_req(OP_SEARCH, 32'h7FFF_FFFF);
		push_drain();

		// random mix drawn mostly from a small pool so hits and repeats happen
		pool_n = 1;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (n % 60 == 0) begin
				pool_n = $urandom_range(2, 16);
				for (i = 0; i < 16; i++) begin
					case ($urandom_range(0, 11))
						0:       pool[i] = 32'h8000_0000;
						1:       pool[i] = 32'h7FFF_FFFF;
						2:       pool[i] = 32'h0000_0000;
						3:       pool[i] = 32'hFFFF_FFFF;
						default: pool[i] = $urandom;
					endcase
				end
			end
			if (n == RANDOM_REQS / 2)
				push_drain();
			v = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
			r = $urandom_range(0, 99);
			if (r < 3)
				push_req(OP_CLEAR, v);
			else if (r < 45)
				push_req(OP_INSERT, v);
			else if (r < 72)
				push_req(OP_SEARCH, v);
			else
				push_req(OP_DELETE, v);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() > 0 || s_tvalid || rsp_queue.size() > 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (fail_count == 0)
			$display("[unordered_value_table] OK");
		else
			$display("[unordered_value_table] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("[unordered_value_table] ERROR");
		$finish;
	end

endmodule
